// ===== rtl/core/sg_pkg.sv =====
`default_nettype none

package sg_pkg;

  // channel count of the pixel ports
  localparam int NCH_IO = 3;

  // field types
  typedef logic [7:0]         pix_t;
  typedef logic signed [10:0] sum_t;
  typedef logic signed [8:0]  res_t;
  typedef logic [15:0]        row_t;
  typedef logic [9:0]         col_t;
  typedef logic [10:0]        width_t;
  typedef logic [15:0]        cfg_data_t;
  typedef logic [1:0]         cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_DIRECTION    = 2'd2;

  // register reset values
  localparam width_t RST_FRAME_WIDTH  = 11'd640;
  localparam row_t   RST_FRAME_HEIGHT = 16'd480;

  // one pixel leaving the lanes: positions, pending results, samples, sums
  typedef struct packed {
    row_t                    int_row;
    col_t                    int_col;
    row_t                    bor_row;
    col_t                    bor_col;
    logic                    has_int;
    logic                    has_bor;
    pix_t [NCH_IO-1:0]       pix;
    sum_t [NCH_IO-1:0]       sum;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/sg_lane.sv =====
`default_nettype none

module sg_lane (
  input  wire logic                  dir,
  input  wire sg_pkg::pix_t [2:0]    lft,
  input  wire sg_pkg::pix_t [2:0]    mid,
  input  wire sg_pkg::pix_t [2:0]    rgt,
  output sg_pkg::sum_t               sum
);

  sg_pkg::sum_t l0, l1, l2, m0, m2, r0, r1, r2;
  sg_pkg::sum_t d0, d1, d2;

  // zero-extend the samples, index 0 is the upper row
  assign l0 = $signed({3'b000, lft[0]});
  assign l1 = $signed({3'b000, lft[1]});
  assign l2 = $signed({3'b000, lft[2]});
  assign m0 = $signed({3'b000, mid[0]});
  assign m2 = $signed({3'b000, mid[2]});
  assign r0 = $signed({3'b000, rgt[0]});
  assign r1 = $signed({3'b000, rgt[1]});
  assign r2 = $signed({3'b000, rgt[2]});

  // x: rows weighted 1,2,1 of left minus right; y: up minus down over columns 1,2,1
  always_comb begin
    if (dir) begin
      d0 = l0 - l2;
      d1 = m0 - m2;
      d2 = r0 - r2;
    end else begin
      d0 = l0 - r0;
      d1 = l1 - r1;
      d2 = l2 - r2;
    end
    sum = d0 + d1 + d1 + d2;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sg_merge.sv =====
`default_nettype none

module sg_merge (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire sg_pkg::item_t item,
  output logic               item_free,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sg_pkg::row_t       out_row,
  output sg_pkg::col_t       out_col,
  output sg_pkg::res_t       out_chan [sg_pkg::NCH_IO],
  output logic               is_border,
  output logic               last_of_run
);

  // divide by 8, round half to even
  function automatic sg_pkg::res_t round_div8(input sg_pkg::sum_t s);
    logic [11:0] u;
    logic [8:0]  q;
    u = {s[10], s} + 12'd1024;
    q = u[11:3];
    if ((u[2:0] > 3'd4) || ((u[2:0] == 3'd4) && q[0])) begin
      q = q + 9'd1;
    end
    return q - 9'd128;
  endfunction

  sg_pkg::item_t hold;
  logic          hold_valid;
  logic          out_load;
  logic          pend_any;
  logic          emit;

  // handshake between the held item and the output register
  assign out_load  = !out_valid || out_ready;
  assign pend_any  = hold.has_int || hold.has_bor;
  assign emit      = hold_valid && pend_any && out_load;
  assign item_free = !hold_valid || !pend_any || (emit && !(hold.has_int && hold.has_bor));

  // held item, interior result drains first
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_valid && item_free) begin
      hold_valid <= 1'b1;
    end else if (item_free) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_free) begin
      hold <= item;
    end else if (emit && hold.has_int) begin
      hold.has_int <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (hold.has_int) begin
        out_row     <= hold.int_row;
        out_col     <= hold.int_col;
        is_border   <= 1'b0;
        last_of_run <= !hold.has_bor;
        for (int i = 0; i < sg_pkg::NCH_IO; i++) begin
          out_chan[i] <= round_div8(hold.sum[i]);
        end
      end else begin
        out_row     <= hold.bor_row;
        out_col     <= hold.bor_col;
        is_border   <= 1'b1;
        last_of_run <= 1'b1;
        for (int i = 0; i < sg_pkg::NCH_IO; i++) begin
          out_chan[i] <= $signed({1'b0, hold.pix[i]});
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sobel_gradient_3x3_filter.sv =====
// path: a result passes the stage 1 registers, the held item and the output register
// throughput: one pixel per cycle while out_ready is high; an interior plus border
//   result pair (last row or column) stalls input as both use the one output register
// reset: synchronous; registers return to 640 x 480, x gradient; counters, window and
//   valid flags clear; the line memory is not cleared and needs no clearing pass
`default_nettype none

module sobel_gradient_3x3_filter #(
  parameter int MAX_WIDTH = 1024,
  parameter int CHANNELS  = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire sg_pkg::cfg_idx_t  cfg_index,
  input  wire sg_pkg::cfg_data_t cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sg_pkg::pix_t      chan0_in,
  input  wire sg_pkg::pix_t      chan1_in,
  input  wire sg_pkg::pix_t      chan2_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sg_pkg::row_t           out_row,
  output sg_pkg::col_t           out_col,
  output sg_pkg::res_t           chan0_out,
  output sg_pkg::res_t           chan1_out,
  output sg_pkg::res_t           chan2_out,
  output logic                   is_border,
  output logic                   last_of_run
);

  localparam int LANES     = (CHANNELS < sg_pkg::NCH_IO) ? CHANNELS : sg_pkg::NCH_IO;
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int MW        = 2 * LANES * 8;
  localparam int MAXW_M1   = MAX_WIDTH - 1;

  // configuration registers
  sg_pkg::width_t frame_width;
  sg_pkg::row_t   frame_height;
  logic           direction;
  logic           cfg_fire;
  logic           geom_write;

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign geom_write = cfg_fire &&
                      ((cfg_index == sg_pkg::REG_FRAME_WIDTH) ||
                       (cfg_index == sg_pkg::REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sg_pkg::RST_FRAME_WIDTH;
      frame_height <= sg_pkg::RST_FRAME_HEIGHT;
      direction    <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        sg_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        sg_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        sg_pkg::REG_DIRECTION:    direction    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // last column and last row of the effective geometry
  logic [CW-1:0] w_last;
  sg_pkg::row_t  h_last;

  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_last = CW'(MAXW_M1);
    end else begin
      w_last = CW'(frame_width - 11'd1);
    end
    h_last = (frame_height == '0) ? '0 : frame_height - 16'd1;
  end

  // input handshake
  logic s1_valid;
  logic s2_free;
  logic s1_adv;
  logic in_fire;

  assign s1_adv   = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;
  assign in_fire  = in_valid && in_ready;

  // raster position
  sg_pkg::row_t  row_count;
  logic [CW-1:0] col_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (geom_write) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_fire) begin
      if (col_count == w_last) begin
        col_count <= '0;
        row_count <= (row_count == h_last) ? '0 : row_count + 16'd1;
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // stage 1: accepted pixel, its position and line memory read
  sg_pkg::pix_t  pix_in [sg_pkg::NCH_IO];
  sg_pkg::pix_t  s1_pix [LANES];
  sg_pkg::row_t  s1_r;
  logic [CW-1:0] s1_c;
  logic          s1_int;
  logic          s1_bor;

  assign pix_in[0] = chan0_in;
  assign pix_in[1] = chan1_in;
  assign pix_in[2] = chan2_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int l = 0; l < LANES; l++) begin
        s1_pix[l] <= pix_in[l];
      end
      s1_r   <= row_count;
      s1_c   <= col_count;
      s1_int <= (row_count >= 16'd2) && (col_count >= CW'(2));
      s1_bor <= (row_count == '0) || (row_count == h_last) ||
                (col_count == '0) || (col_count == w_last);
    end
  end

  // line memory: upper row in the high half, middle row in the low half
  logic [MW-1:0] line_mem [MAX_WIDTH];
  logic [MW-1:0] rdata;
  logic [MW-1:0] wdata;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wdata[(LANES + l) * 8 +: 8] = rdata[l * 8 +: 8];
      wdata[l * 8 +: 8]           = s1_pix[l];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rdata <= line_mem[col_count];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_c] <= wdata;
    end
  end

  // newest column and the two before it, index 0 is the upper row
  sg_pkg::pix_t [2:0] col_now [LANES];
  sg_pkg::pix_t [2:0] win0    [LANES];
  sg_pkg::pix_t [2:0] win1    [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      col_now[l] = {s1_pix[l], rdata[l * 8 +: 8], rdata[(LANES + l) * 8 +: 8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LANES; l++) begin
        win0[l] <= '0;
        win1[l] <= '0;
      end
    end else if (s1_adv) begin
      for (int l = 0; l < LANES; l++) begin
        win1[l] <= win0[l];
        win0[l] <= col_now[l];
      end
    end
  end

  // one gradient lane per channel
  sg_pkg::sum_t lane_sum [LANES];
  sg_pkg::pix_t pix_all  [sg_pkg::NCH_IO];
  sg_pkg::sum_t sum_all  [sg_pkg::NCH_IO];

  for (genvar l = 0; l < sg_pkg::NCH_IO; l++) begin : g_lane
    if (l < LANES) begin : g_used
      sg_lane u_lane (
        .dir (direction),
        .lft (win1[l]),
        .mid (win0[l]),
        .rgt (col_now[l]),
        .sum (lane_sum[l])
      );
      assign pix_all[l] = s1_pix[l];
      assign sum_all[l] = lane_sum[l];
    end else begin : g_unused
      assign pix_all[l] = '0;
      assign sum_all[l] = '0;
    end
  end

  // item handed to the merge stage
  sg_pkg::item_t item;
  logic [CW-1:0] c_m1;

  assign c_m1 = s1_c - CW'(1);

  always_comb begin
    item.int_row = s1_r - 16'd1;
    item.int_col = sg_pkg::col_t'(c_m1);
    item.bor_row = s1_r;
    item.bor_col = sg_pkg::col_t'(s1_c);
    item.has_int = s1_int;
    item.has_bor = s1_bor;
    for (int i = 0; i < sg_pkg::NCH_IO; i++) begin
      item.pix[i] = pix_all[i];
      item.sum[i] = sum_all[i];
    end
  end

  // merge stage and output register
  sg_pkg::res_t out_chan [sg_pkg::NCH_IO];

  sg_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (s1_valid),
    .item        (item),
    .item_free   (s2_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_chan    (out_chan),
    .is_border   (is_border),
    .last_of_run (last_of_run)
  );

  assign chan0_out = out_chan[0];
  assign chan1_out = out_chan[1];
  assign chan2_out = out_chan[2];

endmodule

`default_nettype wire
